// ===== sv/sfh_pkg.sv =====
// Shared types, constants and hash arithmetic for the byte-stream hash block.
// Used by sfh_front, sfh_queue, sfh_back and superfasthash_byte_stream.
package sfh_pkg;

    localparam int LENGTH_WIDTH_DEF = 16;
    localparam int LEN_PORT_WIDTH   = 16;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QUEUE_AW         = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] TAIL_NONE  = 2'd0;
    localparam logic [1:0] TAIL_ONE   = 2'd1;
    localparam logic [1:0] TAIL_TWO   = 2'd2;
    localparam logic [1:0] TAIL_THREE = 2'd3;

    typedef struct packed {
        logic        start;
        logic [31:0] seed;
        logic        word_valid;
        logic [31:0] word;
        logic        finish;
        logic [23:0] tail;
        logic [1:0]  tail_n;
    } sfh_op_t;

    function automatic logic [31:0] sext8(input logic [7:0] b);
        sext8 = {{24{b[7]}}, b};
    endfunction

    function automatic logic [31:0] word_round(input logic [31:0] h_in, input logic [31:0] w);
        logic [31:0] h;
        h = h_in + {16'h0000, w[15:0]};
        h = h ^ ((h << 16) ^ ({16'h0000, w[31:16]} << 11));
        h = h + (h >> 11);
        word_round = h;
    endfunction

    function automatic logic [31:0] tail_mix(input logic [31:0] h_in, input logic [23:0] tail,
                                             input logic [1:0] n);
        logic [31:0] h;
        logic [31:0] t0;
        logic [31:0] t1;
        logic [31:0] t2;
        h  = h_in;
        t0 = sext8(tail[7:0]);
        t1 = sext8(tail[15:8]);
        t2 = sext8(tail[23:16]);
        case (n)
            TAIL_THREE:
            begin
                h = h + ((t1 << 8) + t0);
                h = h ^ ((h << 16) ^ (t2 << 18));
                h = h + (h >> 11);
            end
            TAIL_TWO:
            begin
                h = h + ((t1 << 8) + t0);
                h = h ^ (h << 11);
                h = h + (h >> 17);
            end
            TAIL_ONE:
            begin
                h = h + t0;
                h = h ^ (h << 10);
                h = h + (h >> 1);
            end
            default:
            begin
                h = h_in;
            end
        endcase
        h = h ^ (h << 3);
        h = h + (h >> 5);
        tail_mix = h;
    endfunction

    function automatic logic [31:0] avalanche_end(input logic [31:0] h_in);
        logic [31:0] h;
        h = h_in ^ (h_in << 4);
        h = h + (h >> 17);
        h = h ^ (h << 25);
        h = h + (h >> 6);
        avalanche_end = h;
    endfunction

endpackage

// ===== sv/sfh_front.sv =====
// Front end: accepts message bytes, tracks message length and gathers 32-bit words.
// Emits one operation per byte that seeds, completes a word or ends a message.
// Depends on sfh_pkg.
module sfh_front #(
    parameter int LENGTH_WIDTH = sfh_pkg::LENGTH_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 take,
    input  logic [7:0]                           data_byte,
    input  logic                                 first_of_message,
    input  logic [sfh_pkg::LEN_PORT_WIDTH-1:0]   message_length,
    output logic                                 push,
    output sfh_pkg::sfh_op_t                     op
);

    logic                    active_reg;
    logic                    active_next;
    logic [1:0]              count_reg;
    logic [1:0]              count_next;
    logic [23:0]             gath_reg;
    logic [23:0]             gath_next;
    logic [LENGTH_WIDTH-1:0] rem_reg;
    logic [LENGTH_WIDTH-1:0] rem_next;

    logic [LENGTH_WIDTH-1:0] len;
    logic                    eff_active;
    logic [1:0]              count_cur;
    logic [23:0]             gath_cur;
    logic [LENGTH_WIDTH-1:0] rem_cur;
    logic                    word_done;
    logic                    last;

    always_comb
    begin
        len        = LENGTH_WIDTH'(message_length);
        eff_active = first_of_message ? (len != '0) : active_reg;
        count_cur  = first_of_message ? 2'd0 : count_reg;
        gath_cur   = first_of_message ? 24'h000000 : gath_reg;
        rem_cur    = first_of_message ? len : rem_reg;
        word_done  = (count_cur == 2'd3);
        rem_next   = rem_cur - LENGTH_WIDTH'(1);
        last       = (rem_next == '0);

        if (word_done)
        begin
            gath_next  = 24'h000000;
            count_next = 2'd0;
        end
        else
        begin
            gath_next  = gath_cur | (24'(data_byte) << {count_cur, 3'b000});
            count_next = count_cur + 2'd1;
        end

        op.start      = first_of_message;
        op.seed       = 32'(len);
        op.word_valid = word_done;
        op.word       = {data_byte, gath_cur};
        op.finish     = last;
        op.tail       = gath_next;
        op.tail_n     = count_next;

        push        = take && eff_active && (first_of_message || word_done || last);
        active_next = eff_active && !last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            count_reg  <= 2'd0;
            gath_reg   <= 24'h000000;
            rem_reg    <= '0;
        end
        else if (take)
        begin
            active_reg <= active_next;
            if (active_next)
            begin
                count_reg <= count_next;
                gath_reg  <= gath_next;
                rem_reg   <= rem_next;
            end
            else
            begin
                count_reg <= 2'd0;
                gath_reg  <= 24'h000000;
                rem_reg   <= '0;
            end
        end
    end

endmodule

// ===== sv/sfh_queue.sv =====
// Short queue of hash operations between the front end and the back end.
// Depends on sfh_pkg.
module sfh_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sfh_pkg::sfh_op_t push_op,
    input  logic             pop,
    output logic             full,
    output logic             empty,
    output sfh_pkg::sfh_op_t head
);

    localparam int AW = sfh_pkg::QUEUE_AW;

    sfh_pkg::sfh_op_t mem [sfh_pkg::QUEUE_DEPTH];

    logic [AW:0] wr_ptr_reg;
    logic [AW:0] rd_ptr_reg;

    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[AW] != rd_ptr_reg[AW]) &&
                   (wr_ptr_reg[AW-1:0] == rd_ptr_reg[AW-1:0]);
    assign head  = mem[rd_ptr_reg[AW-1:0]];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg[AW-1:0]] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + (AW + 1)'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + (AW + 1)'(1);
            end
        end
    end

endmodule

// ===== sv/sfh_back.sv =====
// Back end: runs the word rounds on the running hash and the finishing pipeline.
// The finish runs in three registered stages ending in the output register.
// Depends on sfh_pkg.
module sfh_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             empty,
    input  sfh_pkg::sfh_op_t head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [31:0]      hash_value
);

    logic [31:0] hash_reg;
    logic [31:0] h_seeded;
    logic [31:0] h_round;
    logic        advance;

    logic        b_valid_reg;
    logic [31:0] b_hash_reg;
    logic [23:0] b_tail_reg;
    logic [1:0]  b_n_reg;

    logic        c_valid_reg;
    logic [31:0] c_hash_reg;

    logic        out_valid_reg;
    logic [31:0] out_hash_reg;

    always_comb
    begin
        advance  = !out_valid_reg || out_ready;
        pop      = !empty && (!head.finish || advance);
        h_seeded = head.start ? head.seed : hash_reg;
        h_round  = head.word_valid ? sfh_pkg::word_round(h_seeded, head.word) : h_seeded;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg      <= 32'h00000000;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                hash_reg <= head.finish ? 32'h00000000 : h_round;
            end
            if (advance)
            begin
                b_valid_reg   <= pop && head.finish;
                c_valid_reg   <= b_valid_reg;
                out_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_hash_reg   <= h_round;
            b_tail_reg   <= head.tail;
            b_n_reg      <= head.tail_n;
            c_hash_reg   <= sfh_pkg::tail_mix(b_hash_reg, b_tail_reg, b_n_reg);
            out_hash_reg <= sfh_pkg::avalanche_end(c_hash_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = out_hash_reg;

endmodule

// ===== sv/superfasthash_byte_stream.sv =====
// Top level of the byte-stream SuperFastHash block: front end, queue and back end.
// Depends on sfh_pkg, sfh_front, sfh_queue and sfh_back.
//
// Usage:
// The input channel (in_valid, in_ready) carries one message byte per transfer in
// data_byte. The first byte of a message has first_of_message set and brings the
// total byte count in message_length, which seeds the hash. A new first byte
// drops any unfinished message; a first byte with zero length is dropped, and
// bytes outside a message are taken and ignored.
// The output channel (out_valid, out_ready) carries one 32-bit hash_value per
// message, after its last byte.
// Throughput is one byte per cycle while the queue has room. After the edge
// that takes the last byte, the queue hands the operation to a word-round stage,
// then a tail-mix stage, and the output register finishes the avalanche.
// When the receiver stalls, the finish stages hold, word rounds keep running
// from the four-entry queue, and in_ready drops once that queue is full.
// Reset clears the message state, the queue and all valid flags.
module superfasthash_byte_stream #(
    parameter int LENGTH_WIDTH = sfh_pkg::LENGTH_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [7:0]                         data_byte,
    input  logic                               first_of_message,
    input  logic [sfh_pkg::LEN_PORT_WIDTH-1:0] message_length,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [31:0]                        hash_value
);

    logic             take;
    logic             push;
    logic             pop;
    logic             full;
    logic             empty;
    sfh_pkg::sfh_op_t push_op;
    sfh_pkg::sfh_op_t head;

    assign in_ready = !full;
    assign take     = in_valid && in_ready;

    sfh_front #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .take             (take),
        .data_byte        (data_byte),
        .first_of_message (first_of_message),
        .message_length   (message_length),
        .push             (push),
        .op               (push_op)
    );

    sfh_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .full    (full),
        .empty   (empty),
        .head    (head)
    );

    sfh_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (empty),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hash_value (hash_value)
    );

endmodule
